@@ hdl/htsm_pkg.sv @@
// Shared types, codes and constants for the two-wire sensor master.
`timescale 1ns / 1ps
package htsm_pkg;

    localparam int WAIT_WIDTH_DEF   = 24;
    localparam int RESET_CLOCKS_DEF = 9;
    localparam int CFG_WAIT_W       = 24;
    localparam int BIT_W            = 4;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [CFG_WAIT_W-1:0] WAIT_TICKS_RST = 24'd310000;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_INIT = 2'd1;
    localparam logic [1:0] KIND_TEMP = 2'd2;
    localparam logic [1:0] KIND_HUM  = 2'd3;

    localparam logic REG_STATUS = 1'b0;
    localparam logic REG_WAIT   = 1'b1;

    localparam logic [7:0] CMD_INIT = 8'h06;
    localparam logic [7:0] CMD_TEMP = 8'h03;
    localparam logic [7:0] CMD_HUM  = 8'h05;

    localparam logic [1:0] BYTE_FIRST  = 2'd0;
    localparam logic [1:0] BYTE_SECOND = 2'd1;
    localparam logic [1:0] BYTE_THIRD  = 2'd2;
    localparam logic [1:0] BYTE_FOURTH = 2'd3;

    // conversion coefficients, hundredths scaled by 2^20
    localparam int C0_W   = 34;
    localparam int C1_W   = 26;
    localparam int C2_W   = 16;
    localparam int RAW_W  = 16;
    localparam int SQ_W   = 2 * RAW_W;
    localparam int P1_W   = C1_W + RAW_W;
    localparam int P2_W   = C2_W + SQ_W;
    localparam int ACC_W  = 50;
    localparam int FRAC_W = 20;
    localparam int VAL_W  = 16;

    localparam logic signed [C0_W-1:0] TEMP_C0    = -34'sd4204789760;
    localparam logic signed [C0_W-1:0] HUM_C0     = -34'sd455795016;
    localparam logic [C1_W-1:0]        TEMP_C1_LO = 26'd4194304;
    localparam logic [C1_W-1:0]        TEMP_C1_HI = 26'd1048576;
    localparam logic [C1_W-1:0]        HUM_C1_LO  = 26'd61572383;
    localparam logic [C1_W-1:0]        HUM_C1_HI  = 26'd3848274;
    localparam logic [C2_W-1:0]        HUM_C2_LO  = 16'd42829;
    localparam logic [C2_W-1:0]        HUM_C2_HI  = 16'd167;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LO, PH_RST_HI,
        PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5,
        PH_W_LO, PH_W_HI, PH_WAIT, PH_R_LO, PH_R_HI, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        CV_IDLE, CV_MUL1, CV_MUL2, CV_SUM, CV_SAT
    } conv_state_t;

    typedef enum logic [1:0] {
        BIT_HOLD, BIT_CLR, BIT_INC
    } bit_op_t;

    typedef enum logic [2:0] {
        SH_HOLD, SH_CLEAR, SH_LOAD_INIT, SH_LOAD_TEMP, SH_LOAD_HUM,
        SH_LOAD_STATUS, SH_SHIFT
    } shift_op_t;

    typedef struct packed {
        bit_op_t    bit_op;
        logic       byte_we;
        logic [1:0] byte_val;
        shift_op_t  shift_op;
        logic       high_we;
        logic       wait_clr;
        logic       wait_inc;
        logic       lowres_we;
        logic       conv_start;
        logic       conv_hum;
    } dp_cmd_t;

    typedef struct packed {
        logic       bit_lt8;
        logic       rst_last;
        logic       wait_last;
        logic       write_bit;
        logic [1:0] byte_count;
        logic       conv_busy;
    } dp_stat_t;

    typedef struct packed {
        logic clock;
        logic release_n;
        logic busy;
        logic result_valid;
        logic is_humidity;
    } pin_t;

endpackage

@@ hdl/humidity_temperature_sensor_master_core.sv @@
// Top level: register port, sequencer, datapath and output register.
`timescale 1ns / 1ps
// Two-wire humidity/temperature sensor master. Each input beat is one
// half-bit tick and yields exactly one output beat carrying the clock pin
// level, the data pin drive (1 released, 0 pulled low), a busy flag and, on
// the closing tick of a measurement, the raw word and its value in
// hundredths. One beat is taken per clock while the output register drains
// and no conversion runs. After the second data byte of a measurement the
// conversion unit runs through two multiplier stages, a sum and a saturation
// stage; input beats are held off while it runs. status_byte sits at address 0 and
// wait_ticks at address 4; write them only while no sequence runs.
module humidity_temperature_sensor_master_core #(
    parameter int WAIT_WIDTH   = htsm_pkg::WAIT_WIDTH_DEF,
    parameter int RESET_CLOCKS = htsm_pkg::RESET_CLOCKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic                               data_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               clock_out,
    output logic                               data_release,
    output logic                               busy_res,
    output logic                               result_valid,
    output logic                               is_humidity,
    output logic [15:0]                        raw_reading,
    output logic signed [15:0]                 value_hundredths,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [htsm_pkg::PADDR_W-1:0]       paddr,
    input  logic [htsm_pkg::PDATA_W-1:0]       pwdata,
    output logic [htsm_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import htsm_pkg::*;

    localparam int CW = (WAIT_WIDTH < CFG_WAIT_W) ? WAIT_WIDTH : CFG_WAIT_W;

    logic [7:0]              status_reg;
    logic [CW-1:0]           wait_ticks_reg;
    logic                    cfg_we;
    logic                    step;
    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    pin_t                    pins;
    logic [RAW_W-1:0]        raw;
    logic signed [VAL_W-1:0] value;

    logic                    out_valid_reg;
    logic                    clock_reg;
    logic                    release_reg;
    logic                    busy_reg;
    logic                    result_reg;
    logic                    hum_reg;
    logic [RAW_W-1:0]        raw_reg;
    logic signed [VAL_W-1:0] value_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= '0;
            wait_ticks_reg <= WAIT_TICKS_RST[CW-1:0];
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_STATUS)
                status_reg <= pwdata[7:0];
            else
                wait_ticks_reg <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WAIT)
            prdata = PDATA_W'(wait_ticks_reg);
        else
            prdata = PDATA_W'(status_reg);
    end

    assign in_stall = (out_valid_reg && out_stall) || stat.conv_busy;
    assign step     = in_valid && !in_stall;

    htsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .pins  (pins)
    );

    htsm_datapath #(
        .WAIT_WIDTH   (WAIT_WIDTH),
        .RESET_CLOCKS (RESET_CLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_in     (data_in),
        .status_byte (status_reg),
        .wait_ticks  (wait_ticks_reg),
        .stat        (stat),
        .raw         (raw),
        .value       (value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            clock_reg   <= pins.clock;
            release_reg <= pins.release_n;
            busy_reg    <= pins.busy;
            result_reg  <= pins.result_valid;
            hum_reg     <= pins.is_humidity;
            raw_reg     <= pins.result_valid ? raw : '0;
            value_reg   <= pins.result_valid ? value : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign clock_out        = clock_reg;
    assign data_release     = release_reg;
    assign busy_res         = busy_reg;
    assign result_valid     = result_reg;
    assign is_humidity      = hum_reg;
    assign raw_reading      = raw_reg;
    assign value_hundredths = value_reg;

    a_result_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_valid |-> busy_res)
        else $error("result beat outside a sequence");

    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> !clock_out && data_release)
        else $error("pins driven while idle");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |->
            raw_reading == 16'd0 && value_hundredths == 16'sd0 && !is_humidity)
        else $error("result fields set without a result");

    a_conv_done_in_time: assert property (@(posedge clk) disable iff (!rst_n)
        step && pins.result_valid |-> !stat.conv_busy)
        else $error("result taken while conversion runs");

endmodule

@@ hdl/htsm_conv.sv @@
// Multi-cycle conversion of the raw word into hundredths, saturated.
`timescale 1ns / 1ps
module htsm_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          hum,
    input  logic                          lowres,
    input  logic [htsm_pkg::RAW_W-1:0]    raw,
    output logic                          busy,
    output logic signed [htsm_pkg::VAL_W-1:0] value
);
    import htsm_pkg::*;

    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

    conv_state_t state_reg, state_next;

    logic [RAW_W-1:0]          l_reg;
    logic signed [C0_W-1:0]    c0_reg;
    logic [C1_W-1:0]           c1_reg;
    logic [C2_W-1:0]           c2_reg;
    logic [P1_W-1:0]           p1_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [P2_W-1:0]           p2_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [VAL_W-1:0]   value_reg;
    logic signed [ACC_W-1:0]   q_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CV_IDLE: if (start) state_next = CV_MUL1;
            CV_MUL1: state_next = CV_MUL2;
            CV_MUL2: state_next = CV_SUM;
            CV_SUM:  state_next = CV_SAT;
            CV_SAT:  state_next = CV_IDLE;
            default: state_next = CV_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != CV_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign q_full = acc_reg >>> FRAC_W;

    always_ff @(posedge clk)
    begin
        if (state_reg == CV_IDLE && start)
        begin
            l_reg <= raw;
            if (hum)
            begin
                c0_reg <= HUM_C0;
                c1_reg <= lowres ? HUM_C1_LO : HUM_C1_HI;
                c2_reg <= lowres ? HUM_C2_LO : HUM_C2_HI;
            end
            else
            begin
                c0_reg <= TEMP_C0;
                c1_reg <= lowres ? TEMP_C1_LO : TEMP_C1_HI;
                c2_reg <= '0;
            end
        end
        if (state_reg == CV_MUL1)
        begin
            p1_reg <= P1_W'(c1_reg) * P1_W'(l_reg);
            sq_reg <= SQ_W'(l_reg) * SQ_W'(l_reg);
        end
        if (state_reg == CV_MUL2)
        begin
            p2_reg <= P2_W'(c2_reg) * P2_W'(sq_reg);
        end
        if (state_reg == CV_SUM)
        begin
            acc_reg <= {{(ACC_W-C0_W){c0_reg[C0_W-1]}}, c0_reg}
                       + $signed(ACC_W'(p1_reg)) - $signed(ACC_W'(p2_reg));
        end
        if (state_reg == CV_SAT)
        begin
            if (q_full > Q_MAX)
                value_reg <= Q_MAX[VAL_W-1:0];
            else if (q_full < Q_MIN)
                value_reg <= Q_MIN[VAL_W-1:0];
            else
                value_reg <= q_full[VAL_W-1:0];
        end
    end

    assign value = value_reg;

endmodule

@@ hdl/htsm_datapath.sv @@
// Bit and byte counters, shift register, wait counter and conversion unit.
`timescale 1ns / 1ps
module htsm_datapath #(
    parameter int WAIT_WIDTH   = htsm_pkg::WAIT_WIDTH_DEF,
    parameter int RESET_CLOCKS = htsm_pkg::RESET_CLOCKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  htsm_pkg::dp_cmd_t                  cmd,
    input  logic                               data_in,
    input  logic [7:0]                         status_byte,
    input  logic [((WAIT_WIDTH < htsm_pkg::CFG_WAIT_W) ? WAIT_WIDTH
                   : htsm_pkg::CFG_WAIT_W)-1:0] wait_ticks,
    output htsm_pkg::dp_stat_t                 stat,
    output logic [htsm_pkg::RAW_W-1:0]         raw,
    output logic signed [htsm_pkg::VAL_W-1:0]  value
);
    import htsm_pkg::*;

    logic [BIT_W-1:0]      bit_count_reg;
    logic [1:0]            byte_count_reg;
    logic [7:0]            shift_reg;
    logic [7:0]            high_reg;
    logic [WAIT_WIDTH-1:0] wait_count_reg;
    logic                  lowres_reg;
    logic [WAIT_WIDTH-1:0] wait_inc;
    logic [BIT_W:0]        bit_inc;
    logic                  conv_busy;

    assign wait_inc = wait_count_reg + WAIT_WIDTH'(1);
    assign bit_inc  = (BIT_W+1)'(bit_count_reg) + (BIT_W+1)'(1);

    always_comb
    begin
        stat            = '0;
        stat.bit_lt8    = (bit_count_reg < BIT_W'(8));
        stat.rst_last   = (bit_inc >= (BIT_W+1)'(RESET_CLOCKS));
        stat.wait_last  = (32'(wait_inc) >= 32'(wait_ticks));
        stat.write_bit  = stat.bit_lt8 ? shift_reg[3'd7 - bit_count_reg[2:0]] : 1'b1;
        stat.byte_count = byte_count_reg;
        stat.conv_busy  = conv_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= '0;
            byte_count_reg <= '0;
            shift_reg      <= '0;
            high_reg       <= '0;
            wait_count_reg <= '0;
            lowres_reg     <= 1'b0;
        end
        else
        begin
            case (cmd.bit_op)
                BIT_CLR: bit_count_reg <= '0;
                BIT_INC: bit_count_reg <= bit_inc[BIT_W-1:0];
                default: bit_count_reg <= bit_count_reg;
            endcase
            if (cmd.byte_we)
                byte_count_reg <= cmd.byte_val;
            case (cmd.shift_op)
                SH_CLEAR:       shift_reg <= '0;
                SH_LOAD_INIT:   shift_reg <= CMD_INIT;
                SH_LOAD_TEMP:   shift_reg <= CMD_TEMP;
                SH_LOAD_HUM:    shift_reg <= CMD_HUM;
                SH_LOAD_STATUS: shift_reg <= status_byte;
                SH_SHIFT:       shift_reg <= {shift_reg[6:0], data_in};
                default:        shift_reg <= shift_reg;
            endcase
            if (cmd.high_we)
                high_reg <= shift_reg;
            if (cmd.wait_clr)
                wait_count_reg <= '0;
            else if (cmd.wait_inc)
                wait_count_reg <= wait_inc;
            if (cmd.lowres_we)
                lowres_reg <= (status_byte != 8'd0);
        end
    end

    assign raw = {high_reg, shift_reg};

    htsm_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.conv_start),
        .hum    (cmd.conv_hum),
        .lowres (lowres_reg),
        .raw    ({high_reg, shift_reg}),
        .busy   (conv_busy),
        .value  (value)
    );

endmodule

@@ hdl/htsm_ctrl.sv @@
// Sequencer: start, reset-clock, write, wait and read phases, stepped once per accepted tick.
`timescale 1ns / 1ps
module htsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         kind,
    input  htsm_pkg::dp_stat_t stat,
    output htsm_pkg::dp_cmd_t  cmd,
    output htsm_pkg::pin_t     pins
);
    import htsm_pkg::*;

    phase_t phase_reg, phase_next, phase_eff;
    logic   init_reg, init_next, init_eff;
    logic   hum_reg, hum_next, hum_eff;
    logic   start_init, start_meas;

    // a command starts a sequence on the same tick it arrives
    always_comb
    begin
        start_init = (phase_reg == PH_IDLE) && (kind == KIND_INIT);
        start_meas = (phase_reg == PH_IDLE) && (kind == KIND_TEMP || kind == KIND_HUM);
        phase_eff  = phase_reg;
        init_eff   = init_reg;
        hum_eff    = hum_reg;
        if (start_init)
        begin
            phase_eff = PH_RST_LO;
            init_eff  = 1'b1;
        end
        else if (start_meas)
        begin
            phase_eff = PH_S0;
            init_eff  = 1'b0;
            hum_eff   = (kind == KIND_HUM);
        end
    end

    always_comb
    begin
        phase_next = phase_eff;
        init_next  = init_eff;
        hum_next   = hum_eff;
        case (phase_eff)
            PH_IDLE:   phase_next = PH_IDLE;
            PH_RST_LO: phase_next = PH_RST_HI;
            PH_RST_HI: phase_next = stat.rst_last ? PH_S0 : PH_RST_LO;
            PH_S0:     phase_next = PH_S1;
            PH_S1:     phase_next = PH_S2;
            PH_S2:     phase_next = PH_S3;
            PH_S3:     phase_next = PH_S4;
            PH_S4:     phase_next = PH_S5;
            PH_S5:
                phase_next = (init_eff && stat.byte_count == BYTE_FIRST) ? PH_S0 : PH_W_LO;
            PH_W_LO:   phase_next = PH_W_HI;
            PH_W_HI:
            begin
                if (stat.bit_lt8)
                    phase_next = PH_W_LO;
                else if (init_eff && stat.byte_count == BYTE_THIRD)
                    phase_next = PH_W_LO;
                else if (init_eff)
                    phase_next = PH_DONE;
                else
                    phase_next = PH_WAIT;
            end
            PH_WAIT:   phase_next = stat.wait_last ? PH_R_LO : PH_WAIT;
            PH_R_LO:   phase_next = PH_R_HI;
            PH_R_HI:
            begin
                if (stat.bit_lt8 || stat.byte_count != BYTE_THIRD)
                    phase_next = PH_R_LO;
                else
                    phase_next = PH_DONE;
            end
            PH_DONE:
            begin
                phase_next = PH_IDLE;
                init_next  = 1'b0;
            end
            default:   phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.bit_op     = BIT_HOLD;
        cmd.shift_op   = SH_HOLD;
        cmd.conv_hum   = hum_reg;
        pins           = '0;
        pins.release_n = 1'b1;
        pins.busy      = (phase_eff != PH_IDLE);
        if (start_init)
            cmd.bit_op = BIT_CLR;
        if (start_meas)
        begin
            cmd.byte_we  = 1'b1;
            cmd.byte_val = BYTE_FIRST;
        end
        case (phase_eff)
            PH_RST_HI:
            begin
                pins.clock = 1'b1;
                if (stat.rst_last)
                begin
                    cmd.bit_op   = BIT_CLR;
                    cmd.byte_we  = 1'b1;
                    cmd.byte_val = BYTE_FIRST;
                end
                else
                    cmd.bit_op = BIT_INC;
            end
            PH_S1: pins.clock = 1'b1;
            PH_S2:
            begin
                pins.clock     = 1'b1;
                pins.release_n = 1'b0;
            end
            PH_S3: pins.release_n = 1'b0;
            PH_S4:
            begin
                pins.clock     = 1'b1;
                pins.release_n = 1'b0;
            end
            PH_S5:
            begin
                pins.clock  = 1'b1;
                cmd.bit_op  = BIT_CLR;
                cmd.byte_we = 1'b1;
                if (init_eff && stat.byte_count == BYTE_FIRST)
                    cmd.byte_val = BYTE_SECOND;
                else
                begin
                    cmd.byte_val = BYTE_THIRD;
                    if (init_eff)
                        cmd.shift_op = SH_LOAD_INIT;
                    else if (hum_eff)
                        cmd.shift_op = SH_LOAD_HUM;
                    else
                        cmd.shift_op = SH_LOAD_TEMP;
                end
            end
            PH_W_LO: pins.release_n = stat.write_bit;
            PH_W_HI:
            begin
                pins.clock     = 1'b1;
                pins.release_n = stat.write_bit;
                cmd.bit_op     = BIT_INC;
                if (!stat.bit_lt8)
                begin
                    if (init_eff && stat.byte_count == BYTE_THIRD)
                    begin
                        cmd.byte_we   = 1'b1;
                        cmd.byte_val  = BYTE_FOURTH;
                        cmd.bit_op    = BIT_CLR;
                        cmd.shift_op  = SH_LOAD_STATUS;
                        cmd.lowres_we = 1'b1;
                    end
                    else if (!init_eff)
                        cmd.wait_clr = 1'b1;
                end
            end
            PH_WAIT:
            begin
                cmd.wait_inc = 1'b1;
                if (stat.wait_last)
                begin
                    cmd.bit_op   = BIT_CLR;
                    cmd.byte_we  = 1'b1;
                    cmd.byte_val = BYTE_FIRST;
                    cmd.shift_op = SH_CLEAR;
                end
            end
            PH_R_LO: pins.release_n = stat.bit_lt8;
            PH_R_HI:
            begin
                pins.clock     = 1'b1;
                pins.release_n = stat.bit_lt8;
                if (stat.bit_lt8)
                begin
                    cmd.bit_op = BIT_INC;
                    if (stat.byte_count == BYTE_FIRST || stat.byte_count == BYTE_SECOND)
                        cmd.shift_op = SH_SHIFT;
                end
                else
                begin
                    cmd.bit_op = BIT_CLR;
                    if (stat.byte_count == BYTE_FIRST)
                    begin
                        cmd.high_we  = 1'b1;
                        cmd.shift_op = SH_CLEAR;
                        cmd.byte_we  = 1'b1;
                        cmd.byte_val = BYTE_SECOND;
                    end
                    else if (stat.byte_count == BYTE_SECOND)
                    begin
                        cmd.byte_we    = 1'b1;
                        cmd.byte_val   = BYTE_THIRD;
                        cmd.conv_start = 1'b1;
                    end
                end
            end
            PH_DONE:
            begin
                pins.result_valid = !init_eff;
                pins.is_humidity  = !init_eff && hum_eff;
            end
            default:
            begin
                pins.clock = 1'b0;
            end
        endcase
        if (!step)
        begin
            cmd          = '0;
            cmd.bit_op   = BIT_HOLD;
            cmd.shift_op = SH_HOLD;
            cmd.conv_hum = hum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            init_reg  <= 1'b0;
            hum_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            init_reg  <= init_next;
            hum_reg   <= hum_next;
        end
    end

endmodule
